// ----- rtl/core/dsg_pkg.sv -----
// Package for the dual stepper step generator: request and register codes,
// field widths and the command/status structs between controller and datapath.
// No dependencies.
`default_nettype none

package dsg_pkg;

  localparam int SpeedW  = 16;
  localparam int MaxW    = 14;
  localparam int RateW   = 20;
  localparam int PeriodW = 16;
  localparam int PhaseW  = 3;
  localparam int CountW  = 16;
  localparam int CfgIdxW = 1;

  // request codes
  localparam logic [1:0] ReqTick  = 2'd0;
  localparam logic [1:0] ReqLeft  = 2'd1;
  localparam logic [1:0] ReqRight = 2'd2;
  localparam logic [1:0] ReqDrive = 2'd3;

  // register indexes
  localparam logic [CfgIdxW-1:0] CfgMaxSpeed = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgTickRate = 1'b1;

  localparam logic [MaxW-1:0]   MaxSpeedRst = 14'd1000;
  localparam logic [RateW-1:0]  TickRateRst = 20'd57600;
  localparam logic [PhaseW-1:0] PhaseIdle   = 3'd4;
  localparam logic [PeriodW-1:0] PeriodSat  = 16'hFFFF;

  // one quotient bit per divider step
  localparam int DivSteps = RateW;
  localparam int DivCntW  = $clog2(DivSteps);

  typedef struct packed {
    logic cap_in;      // latch the input beat
    logic exec;        // tick update, limit check, step and accept flags
    logic sel_left;    // motor being set: 1 left, 0 right
    logic zero_apply;  // stop the selected motor
    logic div_start;   // load the divider
    logic div_step;    // one quotient bit
    logic write_speed; // store speed and period of the selected motor
    logic load_out;    // capture the result beat
  } dsg_cmd_t;

  typedef struct packed {
    logic [1:0] req;
    logic       over_limit;
    logic       spd_zero;
  } dsg_sts_t;

endpackage

`default_nettype wire

// ----- rtl/core/dsg_chan_if.sv -----
// Valid/ready channel interfaces for request and result beats.
// Depends on dsg_pkg.
`default_nettype none

interface dsg_in_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          req_type;
  logic signed [dsg_pkg::SpeedW-1:0]   speed_a;
  logic signed [dsg_pkg::SpeedW-1:0]   speed_b;

  modport source (output valid, req_type, speed_a, speed_b, input ready);
  modport sink   (input valid, req_type, speed_a, speed_b, output ready);
endinterface

interface dsg_out_if;
  logic                              valid;
  logic                              ready;
  logic [dsg_pkg::PhaseW-1:0]        left_phase;
  logic [dsg_pkg::PhaseW-1:0]        right_phase;
  logic                              left_step;
  logic                              right_step;
  logic [dsg_pkg::CountW-1:0]        left_step_count;
  logic [dsg_pkg::CountW-1:0]        right_step_count;
  logic                              accepted;

  modport source (output valid, left_phase, right_phase, left_step, right_step,
                  left_step_count, right_step_count, accepted, input ready);
  modport sink   (input valid, left_phase, right_phase, left_step, right_step,
                  left_step_count, right_step_count, accepted, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/dsg_div.sv -----
// Restoring divider, one quotient bit per step: tick_rate / |speed|.
// Depends on dsg_pkg.
`default_nettype none

module dsg_div (
  input  wire logic                        clk_i,
  input  wire logic                        start_i,
  input  wire logic                        step_i,
  input  wire logic [dsg_pkg::RateW-1:0]   dividend_i,
  input  wire logic [dsg_pkg::MaxW-1:0]    divisor_i,
  output logic      [dsg_pkg::RateW-1:0]   quot_o
);

  logic [dsg_pkg::MaxW-1:0]  rem_q, rem_d;
  logic [dsg_pkg::MaxW-1:0]  dvs_q;
  logic [dsg_pkg::RateW-1:0] quo_q, quo_d;
  logic [dsg_pkg::MaxW:0]    part;
  logic [dsg_pkg::MaxW:0]    diff;
  logic                      ge;

  always_comb begin
    part  = {rem_q, quo_q[dsg_pkg::RateW-1]};
    ge    = part >= {1'b0, dvs_q};
    diff  = part - {1'b0, dvs_q};
    // remainder stays below the divisor, so it fits in MaxW bits
    rem_d = ge ? diff[dsg_pkg::MaxW-1:0] : part[dsg_pkg::MaxW-1:0];
    quo_d = {quo_q[dsg_pkg::RateW-2:0], ge};
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (step_i) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign quot_o = quo_q;

endmodule

`default_nettype wire

// ----- rtl/core/dsg_dp.sv -----
// Datapath: config registers, request latch, speed clamp, motor state,
// tick stepping and the result register. Uses dsg_div; depends on dsg_pkg.
`default_nettype none

module dsg_dp (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire dsg_pkg::dsg_cmd_t                   cmd_i,
  output dsg_pkg::dsg_sts_t                        sts_o,
  input  wire logic                                cfg_we_i,
  input  wire logic [dsg_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  wire logic [dsg_pkg::RateW-1:0]           cfg_data_i,
  input  wire logic [1:0]                          req_type_i,
  input  wire logic signed [dsg_pkg::SpeedW-1:0]   speed_a_i,
  input  wire logic signed [dsg_pkg::SpeedW-1:0]   speed_b_i,
  output logic [dsg_pkg::PhaseW-1:0]               left_phase_o,
  output logic [dsg_pkg::PhaseW-1:0]               right_phase_o,
  output logic                                     left_step_o,
  output logic                                     right_step_o,
  output logic [dsg_pkg::CountW-1:0]               left_step_count_o,
  output logic [dsg_pkg::CountW-1:0]               right_step_count_o,
  output logic                                     accepted_o
);

  localparam int SumW = dsg_pkg::SpeedW + 2;

  function automatic logic [dsg_pkg::PhaseW-1:0] next_phase(
    input logic [dsg_pkg::PhaseW-1:0] p,
    input logic                       up
  );
    logic [1:0] c;
    c = (p > 3'd3) ? 2'd3 : p[1:0];
    c = up ? c + 2'd1 : c - 2'd1;
    return {1'b0, c};
  endfunction

  // config
  logic [dsg_pkg::MaxW-1:0]  max_q;
  logic [dsg_pkg::RateW-1:0] rate_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q  <= dsg_pkg::MaxSpeedRst;
      rate_q <= dsg_pkg::TickRateRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        dsg_pkg::CfgMaxSpeed: max_q  <= cfg_data_i[dsg_pkg::MaxW-1:0];
        dsg_pkg::CfgTickRate: rate_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // request latch
  logic [1:0]                        req_q;
  logic signed [dsg_pkg::SpeedW-1:0] a_q, b_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_in) begin
      req_q <= req_type_i;
      a_q   <= speed_a_i;
      b_q   <= speed_b_i;
    end
  end

  // limit check and clamp
  logic signed [SumW-1:0]    a_x, b_x, s_raw, s_clp, lim, nlim, s_abs;
  logic [SumW-1:0]           abs_a, abs_b, abs_sum;
  logic                      over, s_zero, s_pos;
  logic [dsg_pkg::MaxW-1:0]  mag;

  always_comb begin
    a_x     = SumW'(a_q);
    b_x     = SumW'(b_q);
    abs_a   = a_x[SumW-1] ? -a_x : a_x;
    abs_b   = b_x[SumW-1] ? -b_x : b_x;
    abs_sum = abs_a + abs_b;
    lim     = $signed({{(SumW-dsg_pkg::MaxW){1'b0}}, max_q});
    over    = abs_sum > lim;
    nlim    = -lim;
    if (req_q == dsg_pkg::ReqDrive) begin
      s_raw = cmd_i.sel_left ? a_x + b_x : a_x - b_x;
    end else begin
      s_raw = a_x;
    end
    if (s_raw > lim) begin
      s_clp = lim;
    end else if (s_raw < nlim) begin
      s_clp = nlim;
    end else begin
      s_clp = s_raw;
    end
    s_zero = s_clp == '0;
    s_pos  = !s_clp[SumW-1] && !s_zero;
    s_abs  = s_clp[SumW-1] ? -s_clp : s_clp;
    mag    = s_abs[dsg_pkg::MaxW-1:0];
  end

  assign sts_o.req        = req_q;
  assign sts_o.over_limit = over;
  assign sts_o.spd_zero   = s_zero;

  // divider
  logic [dsg_pkg::RateW-1:0]   quot;
  logic [dsg_pkg::PeriodW-1:0] period_new;

  dsg_div u_div (
    .clk_i      (clk_i),
    .start_i    (cmd_i.div_start),
    .step_i     (cmd_i.div_step),
    .dividend_i (rate_q),
    .divisor_i  (mag),
    .quot_o     (quot)
  );

  assign period_new = (quot[dsg_pkg::RateW-1:dsg_pkg::PeriodW] != '0) ?
                      dsg_pkg::PeriodSat : quot[dsg_pkg::PeriodW-1:0];

  // motor state
  logic                         l_run_q, r_run_q, l_pos_q, r_pos_q;
  logic [dsg_pkg::PeriodW-1:0]  l_per_q, r_per_q, l_tmr_q, r_tmr_q;
  logic [dsg_pkg::PhaseW-1:0]   l_ph_q, r_ph_q;
  logic [dsg_pkg::CountW-1:0]   l_cnt_q, r_cnt_q;
  logic                         l_step_q, r_step_q, acc_q;
  logic                         is_tick, l_hit, r_hit;
  logic                         set_l, set_r;

  assign is_tick = req_q == dsg_pkg::ReqTick;
  assign l_hit   = l_run_q && (l_tmr_q == l_per_q);
  assign r_hit   = r_run_q && (r_tmr_q == r_per_q);
  assign set_l   = cmd_i.sel_left;
  assign set_r   = !cmd_i.sel_left;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l_run_q  <= 1'b0;
      r_run_q  <= 1'b0;
      l_pos_q  <= 1'b0;
      r_pos_q  <= 1'b0;
      l_per_q  <= '0;
      r_per_q  <= '0;
      l_tmr_q  <= '0;
      r_tmr_q  <= '0;
      l_ph_q   <= dsg_pkg::PhaseIdle;
      r_ph_q   <= dsg_pkg::PhaseIdle;
      l_cnt_q  <= '0;
      r_cnt_q  <= '0;
      l_step_q <= 1'b0;
      r_step_q <= 1'b0;
      acc_q    <= 1'b1;
    end else begin
      if (cmd_i.exec) begin
        l_step_q <= is_tick && l_hit;
        r_step_q <= is_tick && r_hit;
        acc_q    <= !((req_q == dsg_pkg::ReqDrive) && over);
        if (is_tick) begin
          if (l_hit) begin
            l_tmr_q <= '0;
            l_ph_q  <= next_phase(l_ph_q, !l_pos_q);
            l_cnt_q <= l_cnt_q + 1'b1;
          end else if (l_run_q) begin
            l_tmr_q <= l_tmr_q + 1'b1;
          end
          if (r_hit) begin
            r_tmr_q <= '0;
            r_ph_q  <= next_phase(r_ph_q, r_pos_q);
            r_cnt_q <= r_cnt_q + 1'b1;
          end else if (r_run_q) begin
            r_tmr_q <= r_tmr_q + 1'b1;
          end
        end
      end
      if (cmd_i.zero_apply) begin
        if (set_l) begin
          l_run_q <= 1'b0;
          l_per_q <= '0;
          l_tmr_q <= '0;
          l_ph_q  <= dsg_pkg::PhaseIdle;
        end
        if (set_r) begin
          r_run_q <= 1'b0;
          r_per_q <= '0;
          r_tmr_q <= '0;
          r_ph_q  <= dsg_pkg::PhaseIdle;
        end
      end
      if (cmd_i.write_speed) begin
        if (set_l) begin
          l_run_q <= 1'b1;
          l_pos_q <= s_pos;
          l_per_q <= period_new;
          l_tmr_q <= '0;
        end
        if (set_r) begin
          r_run_q <= 1'b1;
          r_pos_q <= s_pos;
          r_per_q <= period_new;
          r_tmr_q <= '0;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      left_phase_o       <= l_ph_q;
      right_phase_o      <= r_ph_q;
      left_step_o        <= l_step_q;
      right_step_o       <= r_step_q;
      left_step_count_o  <= l_cnt_q;
      right_step_count_o <= r_cnt_q;
      accepted_o         <= acc_q;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/dsg_ctrl.sv -----
// Controller: sequences decode, speed setup, divider steps and result beat.
// Depends on dsg_pkg.
`default_nettype none

module dsg_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  input  wire dsg_pkg::dsg_sts_t  sts_i,
  output dsg_pkg::dsg_cmd_t       cmd_o
);

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StDecode = 3'd1;
  localparam logic [2:0] StSetup  = 3'd2;
  localparam logic [2:0] StDiv    = 3'd3;
  localparam logic [2:0] StWrite  = 3'd4;
  localparam logic [2:0] StFin    = 3'd5;

  logic [2:0]                   state_q, state_d;
  logic [dsg_pkg::DivCntW-1:0]  cnt_q, cnt_d;
  logic                         sel_left_q, sel_left_d;
  logic                         second_q, second_d;
  logic                         out_valid_q, out_valid_d;
  logic                         slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    sel_left_d  = sel_left_q;
    second_d    = second_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    cmd_o.sel_left = sel_left_q;
    in_ready_o  = 1'b0;

    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.cap_in = 1'b1;
          state_d      = StDecode;
        end
      end
      StDecode: begin
        cmd_o.exec = 1'b1;
        second_d   = 1'b0;
        unique case (sts_i.req)
          dsg_pkg::ReqTick:  state_d = StFin;
          dsg_pkg::ReqLeft: begin
            sel_left_d = 1'b1;
            state_d    = StSetup;
          end
          dsg_pkg::ReqRight: begin
            sel_left_d = 1'b0;
            state_d    = StSetup;
          end
          dsg_pkg::ReqDrive: begin
            if (sts_i.over_limit) begin
              state_d = StFin;
            end else begin
              // right first, then left
              sel_left_d = 1'b0;
              second_d   = 1'b1;
              state_d    = StSetup;
            end
          end
          default: state_d = StFin;
        endcase
      end
      StSetup: begin
        if (sts_i.spd_zero) begin
          cmd_o.zero_apply = 1'b1;
          if (second_q) begin
            second_d   = 1'b0;
            sel_left_d = 1'b1;
          end else begin
            state_d = StFin;
          end
        end else begin
          cmd_o.div_start = 1'b1;
          cnt_d           = '0;
          state_d         = StDiv;
        end
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == dsg_pkg::DivCntW'(dsg_pkg::DivSteps - 1)) begin
          state_d = StWrite;
        end
      end
      StWrite: begin
        cmd_o.write_speed = 1'b1;
        if (second_q) begin
          second_d   = 1'b0;
          sel_left_d = 1'b1;
          state_d    = StSetup;
        end else begin
          state_d = StFin;
        end
      end
      StFin: begin
        if (slot_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      sel_left_q  <= 1'b0;
      second_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      sel_left_q  <= sel_left_d;
      second_q    <= second_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> slot_free)
    else $error("result beat loaded over an untaken one");

  a_accept_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == StDecode))
    else $error("accepted beat not decoded");

  a_second_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    second_q |-> (state_q == StSetup || state_q == StDiv || state_q == StWrite))
    else $error("pending left update outside speed setup");

  a_second_right: assert property (@(posedge clk_i) disable iff (!rst_ni)
    second_q |-> !sel_left_q)
    else $error("drive command must set the right motor first");

  a_div_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StWrite) |-> ($past(state_q) == StDiv &&
                              $past(cnt_q) == dsg_pkg::DivCntW'(dsg_pkg::DivSteps - 1)))
    else $error("divider stopped early");

endmodule

`default_nettype wire

// ----- rtl/core/dual_stepper_step_generator.sv -----
// Top level of the dual stepper step generator: controller plus datapath.
// Depends on dsg_pkg, dsg_chan_if, dsg_ctrl, dsg_dp, dsg_div.
//
//   channel   dir  handshake        payload
//   in_if     in   valid/ready      req_type, speed_a, speed_b
//   out_if    out  valid/ready      phases, step flags, step counts, accepted
//   cfg       in   cfg_we_i         cfg_idx_i, cfg_data_i (no read-back)
//
// One beat at a time. Tick or rejected drive: decode, then the result beat.
// Speed command: a zero speed stops the motor without a division, else the
// 20-step divider sets the period. Drive command: the divider runs at most once per motor.
// Reset clears all motor state; a pending result holds until out_if.ready,
// and the next request is taken while it waits.
`default_nettype none

module dual_stepper_step_generator (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  dsg_in_if.sink                             in_if,
  dsg_out_if.source                          out_if,
  input  wire logic                          cfg_we_i,
  input  wire logic [dsg_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [dsg_pkg::RateW-1:0]     cfg_data_i
);

  dsg_pkg::dsg_cmd_t cmd;
  dsg_pkg::dsg_sts_t sts;

  dsg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  dsg_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .req_type_i         (in_if.req_type),
    .speed_a_i          (in_if.speed_a),
    .speed_b_i          (in_if.speed_b),
    .left_phase_o       (out_if.left_phase),
    .right_phase_o      (out_if.right_phase),
    .left_step_o        (out_if.left_step),
    .right_step_o       (out_if.right_step),
    .left_step_count_o  (out_if.left_step_count),
    .right_step_count_o (out_if.right_step_count),
    .accepted_o         (out_if.accepted)
  );

endmodule

`default_nettype wire
